### rtl/metadata_record_crc_checker_macros.svh
// assertion helpers used by the checker top level
`ifndef METADATA_RECORD_CRC_CHECKER_MACROS_SVH
`define METADATA_RECORD_CRC_CHECKER_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define MRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define MRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// types, codes and the crc byte update for the record crc checker
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned LIMIT_W   = 16;
    localparam int unsigned CRC_W     = 32;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
    localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFFFFFF;
    localparam logic [2:0]       HEADER_BYTES = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_APP_A_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_APP_B_LIMIT = 2'd2;

    localparam logic [1:0] REGION_BOOT  = 2'd0;
    localparam logic [1:0] REGION_APP_A = 2'd1;
    localparam logic [1:0] REGION_APP_B = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd4096;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_INVALID = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0] region;
        logic       record_start;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [CRC_W-1:0] computed_crc;
    } t_result;

    typedef struct packed {
        logic          valid;
        t_result       res;
    } t_res_word;

    typedef struct packed {
        logic [LIMIT_W-1:0] boot;
        logic [LIMIT_W-1:0] app_a;
        logic [LIMIT_W-1:0] app_b;
    } t_limits;

    // reflected crc-32, one byte, eight bit steps
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/mrc_cfg_regs.sv
// ----------------------------------------------------------------------------
// mrc_cfg_regs
// region limit registers written through the configuration channel
// ----------------------------------------------------------------------------
module mrc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [mrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mrc_pkg::LIMIT_W-1:0]     i_cfg_data,
    output mrc_pkg::t_limits                o_limits
);
    import mrc_pkg::*;

    t_limits r_limits;
    t_limits n_limits;

    always_comb begin
        n_limits = r_limits;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BOOT_LIMIT:  n_limits.boot  = i_cfg_data;
                CFG_APP_A_LIMIT: n_limits.app_a = i_cfg_data;
                CFG_APP_B_LIMIT: n_limits.app_b = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.boot  <= LIMIT_RESET;
            r_limits.app_a <= LIMIT_RESET;
            r_limits.app_b <= LIMIT_RESET;
        end else begin
            r_limits <= n_limits;
        end
    end

    assign o_limits = r_limits;

endmodule

### rtl/mrc_in_stage.sv
// ----------------------------------------------------------------------------
// mrc_in_stage
// input register; refills in the same cycle the held word moves on
// ----------------------------------------------------------------------------
module mrc_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  mrc_pkg::t_in_item   i_item,
    input  logic                i_advance,
    output logic                o_valid,
    output mrc_pkg::t_in_item   o_item
);
    import mrc_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/mrc_record_core.sv
// ----------------------------------------------------------------------------
// mrc_record_core
// header parse, limit check and body crc, one byte per advance
// ----------------------------------------------------------------------------
module mrc_record_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  mrc_pkg::t_in_item   i_item,
    input  mrc_pkg::t_limits    i_limits,
    output mrc_pkg::t_res_word  o_res
);
    import mrc_pkg::*;

    logic [2:0]             r_hp,     n_hp;
    logic [CRC_W-1:0]       r_stored, n_stored;
    logic [LIMIT_W-1:0]     r_len,    n_len;
    logic [LIMIT_W-1:0]     r_rem,    n_rem;
    logic [CRC_W-1:0]       r_crc,    n_crc;
    logic                   r_active, n_active;
    logic [1:0]             r_region, n_region;
    logic [LIMIT_W-1:0]     limit;
    logic [CRC_W-1:0]       fin;

    always_comb begin
        n_hp     = r_hp;
        n_stored = r_stored;
        n_len    = r_len;
        n_rem    = r_rem;
        n_crc    = r_crc;
        n_active = r_active;
        n_region = r_region;
        limit    = '0;
        fin      = '0;
        o_res.valid            = 1'b0;
        o_res.res.status       = ST_VALID;
        o_res.res.computed_crc = '0;

        if (i_advance && (i_item.record_start || r_active)) begin
            // a start byte drops any record in progress
            if (i_item.record_start) begin
                n_active = 1'b1;
                n_region = i_item.region;
                n_hp     = '0;
                n_stored = '0;
                n_len    = '0;
                n_rem    = '0;
                n_crc    = CRC_ONES;
            end

            if (n_hp < HEADER_BYTES) begin
                if (n_hp[2]) begin
                    n_len[{n_hp[0], 3'b000} +: 8] = i_item.data_byte;
                end else begin
                    n_stored[{n_hp[1:0], 3'b000} +: 8] = i_item.data_byte;
                end
                n_hp = n_hp + 3'd1;

                if (n_hp == HEADER_BYTES) begin
                    unique case (n_region)
                        REGION_BOOT:  limit = i_limits.boot;
                        REGION_APP_A: limit = i_limits.app_a;
                        REGION_APP_B: limit = i_limits.app_b;
                        default:      limit = '0;
                    endcase

                    if (n_len > limit) begin
                        o_res.valid      = 1'b1;
                        o_res.res.status = ST_MISSING;
                        n_active         = 1'b0;
                    end else begin
                        n_crc = CRC_ONES;
                        if (n_len == '0) begin
                            // empty body: crc of nothing is zero
                            o_res.valid      = 1'b1;
                            o_res.res.status = (n_stored == '0) ? ST_VALID : ST_INVALID;
                            n_active         = 1'b0;
                        end else begin
                            n_rem = n_len;
                        end
                    end
                end
            end else begin
                n_crc = crc_byte(n_crc, i_item.data_byte);
                n_rem = n_rem - 16'd1;
                if (n_rem == '0) begin
                    fin                    = ~n_crc;
                    o_res.valid            = 1'b1;
                    o_res.res.status       = (fin == n_stored) ? ST_VALID : ST_INVALID;
                    o_res.res.computed_crc = fin;
                    n_active               = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp     <= '0;
            r_stored <= '0;
            r_len    <= '0;
            r_rem    <= '0;
            r_crc    <= CRC_ONES;
            r_active <= 1'b0;
            r_region <= '0;
        end else begin
            r_hp     <= n_hp;
            r_stored <= n_stored;
            r_len    <= n_len;
            r_rem    <= n_rem;
            r_crc    <= n_crc;
            r_active <= n_active;
            r_region <= n_region;
        end
    end

endmodule

### rtl/mrc_out_stage.sv
// ----------------------------------------------------------------------------
// mrc_out_stage
// result register toward the master side
// ----------------------------------------------------------------------------
module mrc_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  mrc_pkg::t_res_word  i_res,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output mrc_pkg::t_result    o_res
);
    import mrc_pkg::*;

    logic    r_valid;
    logic    n_valid;
    logic    load;
    t_result r_res;

    assign o_free = !r_valid || i_ready;
    assign load   = i_advance && i_res.valid;

    always_comb begin
        n_valid = r_valid;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_res.res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### rtl/metadata_record_crc_checker.sv
// a byte goes from the input register through the core to the result register
// throughput: one byte per cycle unless stalled; crc byte update is one combinational step
// a held result stalls the core; the input register takes one more word meanwhile
// reset (i_rst_n low, synchronous): limits return to 4096, block idle, no result pending
// ----------------------------------------------------------------------------
// metadata_record_crc_checker
// checks the reflected crc-32 of a record body against the crc in its header
// ----------------------------------------------------------------------------
`include "metadata_record_crc_checker_macros.svh"

module metadata_record_crc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,  // [7:0] data_byte
    input  logic [7:0]                      i_s_axis_tuser,  // [0] record_start, [2:1] region
    // master side
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [31:0]                     o_m_axis_tdata,  // [31:0] computed_crc
    output logic [7:0]                      o_m_axis_tuser,  // [1:0] status
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mrc_pkg::LIMIT_W-1:0]     i_cfg_data
);
    import mrc_pkg::*;

    t_in_item  w_s_item;
    t_in_item  w_item;
    t_limits   w_limits;
    t_res_word w_res;
    t_result   w_out;
    logic      w_in_valid;
    logic      w_out_free;
    logic      w_advance;
    logic      w_out_missing;
    logic      w_out_stall;

    assign o_cfg_ready = 1'b1;

    assign w_s_item.data_byte    = i_s_axis_tdata;
    assign w_s_item.record_start = i_s_axis_tuser[0];
    assign w_s_item.region       = i_s_axis_tuser[2:1];

    assign w_advance = w_in_valid && w_out_free;

    mrc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_limits    (w_limits)
    );

    mrc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (w_s_item),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_item    (w_item)
    );

    mrc_record_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (w_item),
        .i_limits  (w_limits),
        .o_res     (w_res)
    );

    mrc_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_res     (w_res),
        .o_free    (w_out_free),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_res     (w_out)
    );

    assign o_m_axis_tdata = w_out.computed_crc;
    assign o_m_axis_tuser = {6'd0, w_out.status};

    assign w_out_missing = o_m_axis_tvalid && (w_out.status == ST_MISSING);
    assign w_out_stall   = o_m_axis_tvalid && !i_m_axis_tready;

    // a missing record never carries a crc
    `MRC_ASSERT_NOW(a_missing_zero_crc, w_out_missing, o_m_axis_tdata == '0)
    // status code three is never produced
    `MRC_ASSERT_NOW(a_status_legal, o_m_axis_tvalid, o_m_axis_tuser[1:0] != 2'd3)
    // a stalled result with a word waiting blocks the slave side
    `MRC_ASSERT_NOW(a_stall_blocks_input, w_in_valid && w_out_stall, !o_s_axis_tready)
    // a word blocked by a full result register stays in the input register
    `MRC_ASSERT_NEXT(a_word_held, w_in_valid && !w_out_free, w_in_valid)

endmodule
